// File: hw/rtl/gda_pkg.sv
// Package for the Gregorian date unit: item types, command and opcode codes,
// calendar constants and month tables. No dependencies.
package gda_pkg;

  localparam int unsigned MAX_YEAR  = 9999;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned COUNT_W   = 22;
  localparam int unsigned IVAL_W    = 23;
  localparam int unsigned DOY_W     = 9;
  localparam int unsigned DN_W      = 25;
  localparam int unsigned REM_W     = 24;

  localparam logic [REM_W-1:0] DAYS_400Y = 24'd146097;
  localparam logic [REM_W-1:0] DAYS_100Y = 24'd36524;
  localparam logic [REM_W-1:0] DAYS_4Y   = 24'd1461;
  localparam logic [REM_W-1:0] DAYS_1Y   = 24'd365;
  localparam logic [10:0] RECIP_25  = 11'd1311;
  localparam logic [10:0] MUL_365   = 11'd365;
  localparam logic [10:0] MUL_400   = 11'd400;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SUB  = 2'd1;
  localparam logic [1:0] CMD_DIFF = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [COUNT_W-1:0] day_count;
    logic [YEAR_W-1:0]  other_year;
    logic [MONTH_W-1:0] other_month;
    logic [DAY_W-1:0]   other_day;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic [IVAL_W-1:0]  interval;
    logic               is_greater;
    logic               is_equal;
    logic [DOY_W-1:0]   day_of_year;
    logic               out_of_range;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_Q100, OP_Q400, OP_Q25, OP_M365, OP_DN,
    OP_SHIFT, OP_CQ, OP_CC, OP_CF, OP_CK, OP_CM, OP_FIN, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       neg;
    logic       take;
    logic       out_free;
  } sts_t;

  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic lp);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                   n = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/gda_in_if.sv
// Input channel of the Gregorian date unit: valid/ready plus one request item.
// Depends on gda_pkg.
interface gda_in_if;
  logic               valid;
  logic               ready;
  gda_pkg::in_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/gda_out_if.sv
// Result channel of the Gregorian date unit: valid/ready plus one result item.
// Depends on gda_pkg.
interface gda_out_if;
  logic               valid;
  logic               ready;
  gda_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/gregorian_date_arithmetic.sv
// Gregorian date unit top level: controller plus datapath on valid/ready channels.
// Depends on gda_pkg, gda_in_if, gda_out_if, gda_ctrl, gda_datapath.
//
// One request at a time. Add/subtract run the datapath's carry loop, which peels
// off Q (up to 69), the number of 400-year periods in the target day number, then
// C <= 3 centuries, F <= 24 four-year blocks, K <= 3 years and M <= 11 months, one
// per cycle; a shift whose day number falls below zero skips the loop. A plain
// compare and a difference do not enter it. A finished result waits in S_DONE
// while the output register is busy, and in the output register while the next
// request is accepted.
module gregorian_date_arithmetic (
  input logic       clk,
  input logic       rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch
);

  gda_pkg::ctl_t ctl;
  gda_pkg::sts_t sts;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  gda_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

// File: hw/rtl/gda_datapath.sv
// Datapath of the Gregorian date unit: operand registers, shared constant
// multiplier, day-number and calendar-carry logic, output register. Uses gda_pkg.
module gda_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  gda_pkg::ctl_t      ctl,
  output gda_pkg::sts_t      sts,
  input  gda_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gda_pkg::out_item_t out_data
);

  logic [1:0]  cmd_r;
  logic [13:0] y1_r, y2_r;
  logic [3:0]  m1_r, m2_r;
  logic [4:0]  d1_r, d2_r;
  logic [21:0] cnt_r;

  logic [7:0]  q100_r, q25_r;
  logic [5:0]  q400_r;
  logic [22:0] y365_r;
  logic signed [24:0] n1_r;

  logic [23:0] r_r;
  logic [6:0]  q_r;
  logic [1:0]  c_r, k_r;
  logic [4:0]  f_r;
  logic [3:0]  mo_r;

  logic [13:0] ry_r;
  logic [3:0]  rm_r;
  logic [4:0]  rd_r;
  logic [22:0] iv_r;
  logic [8:0]  doy_r;
  logic        oor_r;
  logic        out_valid_r;
  gda_pkg::out_item_t res_r;

  logic [13:0] ys;
  logic [3:0]  ms, mm;
  logic [4:0]  ds;
  logic [14:0] mul_a;
  logic [10:0] mul_k;
  logic [25:0] mul_p;
  logic        y4, div100, lp, lp_t;
  logic [11:0] q25x;
  logic [8:0]  ord;
  logic [12:0] a4;
  logic signed [24:0] dn, diff, t;
  logic [22:0] sat;
  logic [23:0] clen, flen, ylen, mlen;
  logic [16:0] ty;
  logic        ty_bad, take, gt, eq;

  assign ys = ctl.sel ? y2_r : y1_r;
  assign ms = ctl.sel ? m2_r : m1_r;
  assign ds = ctl.sel ? d2_r : d1_r;

  always_comb begin
    mul_a = '0;
    mul_k = '0;
    unique case (ctl.op)
      gda_pkg::OP_Q100: begin
        mul_a = 15'((({1'b0, ys} + 15'd99) >> 2));
        mul_k = gda_pkg::RECIP_25;
      end
      gda_pkg::OP_Q400: begin
        mul_a = 15'((({1'b0, ys} + 15'd399) >> 4));
        mul_k = gda_pkg::RECIP_25;
      end
      gda_pkg::OP_Q25: begin
        mul_a = {3'b0, ys[13:2]};
        mul_k = gda_pkg::RECIP_25;
      end
      gda_pkg::OP_M365: begin
        mul_a = {1'b0, ys};
        mul_k = gda_pkg::MUL_365;
      end
      gda_pkg::OP_FIN: begin
        mul_a = {8'b0, q_r};
        mul_k = gda_pkg::MUL_400;
      end
      default: ;
    endcase
  end

  assign mul_p = {11'b0, mul_a} * {15'b0, mul_k};

  always_comb begin
    if (ms == 4'd0)      mm = 4'd1;
    else if (ms > 4'd12) mm = 4'd12;
    else                 mm = ms;
  end

  assign y4     = (ys[1:0] == 2'd0);
  assign q25x   = 12'({4'b0, q25_r} * 12'd25);
  assign div100 = y4 && (q25x == ys[13:2]);
  assign lp     = y4 && (!div100 || (ys[3:0] == 4'd0));
  assign ord    = {4'b0, ds} + gda_pkg::cum_days(mm) + {8'b0, (lp && (mm > 4'd2))};
  assign a4     = 13'((({1'b0, ys} + 15'd3) >> 2));

  assign dn = $signed({2'b00, y365_r}) + $signed({12'b0, a4}) - $signed({17'b0, q100_r})
            + $signed({19'b0, q400_r}) + $signed({16'b0, ord}) - 25'sd1;
  assign diff = n1_r - dn;

  always_comb begin
    if (diff > 25'sd4194303)       sat = 23'h3FFFFF;
    else if (diff < -25'sd4194304) sat = 23'h400000;
    else                           sat = diff[22:0];
  end

  assign t = (cmd_r == gda_pkg::CMD_SUB) ? n1_r - $signed({3'b0, cnt_r})
                                         : n1_r + $signed({3'b0, cnt_r});

  assign lp_t = (k_r == 2'd0) && ((f_r != 5'd0) || (c_r == 2'd0));
  assign clen = (c_r == 2'd0) ? gda_pkg::DAYS_100Y + 24'd1 : gda_pkg::DAYS_100Y;
  assign flen = ((f_r == 5'd0) && (c_r != 2'd0)) ? gda_pkg::DAYS_4Y - 24'd1
                                                 : gda_pkg::DAYS_4Y;
  assign ylen = gda_pkg::DAYS_1Y + {23'b0, lp_t};
  assign mlen = {19'b0, gda_pkg::month_days(mo_r, lp_t)};

  always_comb begin
    unique case (ctl.op)
      gda_pkg::OP_CQ: take = (r_r >= gda_pkg::DAYS_400Y);
      gda_pkg::OP_CC: take = (c_r != 2'd3) && (r_r >= clen);
      gda_pkg::OP_CF: take = (f_r != 5'd24) && (r_r >= flen);
      gda_pkg::OP_CK: take = (k_r != 2'd3) && (r_r >= ylen);
      gda_pkg::OP_CM: take = (mo_r != 4'd12) && (r_r >= mlen);
      default:        take = 1'b0;
    endcase
  end

  assign ty = mul_p[16:0] + ({15'b0, c_r} * 17'd100) + {10'b0, f_r, 2'b0} + {15'b0, k_r};
  assign ty_bad = (ty == 17'd0) || (ty > 17'(gda_pkg::MAX_YEAR)) || (ty > 17'd16383);

  assign gt = (y1_r > y2_r) || ((y1_r == y2_r) && (m1_r > m2_r))
           || ((y1_r == y2_r) && (m1_r == m2_r) && (d1_r > d2_r));
  assign eq = (y1_r == y2_r) && (m1_r == m2_r) && (d1_r == d2_r);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      gda_pkg::OP_LOAD: begin
        cmd_r <= in_data.command;
        y1_r  <= in_data.year;
        m1_r  <= in_data.month;
        d1_r  <= in_data.day;
        cnt_r <= in_data.day_count;
        y2_r  <= in_data.other_year;
        m2_r  <= in_data.other_month;
        d2_r  <= in_data.other_day;
        ry_r  <= in_data.year;
        rm_r  <= in_data.month;
        rd_r  <= in_data.day;
        iv_r  <= '0;
        oor_r <= 1'b0;
      end
      gda_pkg::OP_Q100: q100_r <= mul_p[22:15];
      gda_pkg::OP_Q400: q400_r <= mul_p[20:15];
      gda_pkg::OP_Q25:  q25_r  <= mul_p[22:15];
      gda_pkg::OP_M365: y365_r <= mul_p[22:0];
      gda_pkg::OP_DN: begin
        if (ctl.sel) begin
          iv_r <= sat;
        end else begin
          n1_r  <= dn;
          doy_r <= ord;
        end
      end
      gda_pkg::OP_SHIFT: begin
        r_r  <= t[23:0];
        q_r  <= '0;
        c_r  <= '0;
        f_r  <= '0;
        k_r  <= '0;
        mo_r <= 4'd1;
        if (t[24]) oor_r <= 1'b1;
      end
      gda_pkg::OP_CQ: if (take) begin
        r_r <= r_r - gda_pkg::DAYS_400Y;
        q_r <= q_r + 7'd1;
      end
      gda_pkg::OP_CC: if (take) begin
        r_r <= r_r - clen;
        c_r <= c_r + 2'd1;
      end
      gda_pkg::OP_CF: if (take) begin
        r_r <= r_r - flen;
        f_r <= f_r + 5'd1;
      end
      gda_pkg::OP_CK: if (take) begin
        r_r <= r_r - ylen;
        k_r <= k_r + 2'd1;
      end
      gda_pkg::OP_CM: if (take) begin
        r_r  <= r_r - mlen;
        mo_r <= mo_r + 4'd1;
      end
      gda_pkg::OP_FIN: begin
        if (ty_bad) begin
          oor_r <= 1'b1;
        end else begin
          ry_r <= ty[13:0];
          rm_r <= mo_r;
          rd_r <= r_r[4:0] + 5'd1;
        end
      end
      gda_pkg::OP_OUT: begin
        res_r.result_year  <= ry_r;
        res_r.result_month <= rm_r;
        res_r.result_day   <= rd_r;
        res_r.interval     <= iv_r;
        res_r.is_greater   <= gt;
        res_r.is_equal     <= eq;
        res_r.day_of_year  <= doy_r;
        res_r.out_of_range <= oor_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == gda_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = res_r;
  assign sts.cmd      = cmd_r;
  assign sts.neg      = t[24];
  assign sts.take     = take;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// File: hw/rtl/gda_ctrl.sv
// Controller of the Gregorian date unit: one-hot sequencer issuing datapath
// opcodes. Uses gda_pkg.
module gda_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gda_pkg::sts_t sts,
  output gda_pkg::ctl_t ctl
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_Q100  = 14'b00000000000010,
    S_Q400  = 14'b00000000000100,
    S_Q25   = 14'b00000000001000,
    S_M365  = 14'b00000000010000,
    S_DN    = 14'b00000000100000,
    S_SHIFT = 14'b00000001000000,
    S_CQ    = 14'b00000010000000,
    S_CC    = 14'b00000100000000,
    S_CF    = 14'b00001000000000,
    S_CK    = 14'b00010000000000,
    S_CM    = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;
  logic   in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ctl.op    = gda_pkg::OP_NONE;
    ctl.sel   = sel_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        ctl.op    = gda_pkg::OP_LOAD;
        sel_nxt   = 1'b0;
        state_nxt = S_Q100;
      end
      S_Q100: begin
        ctl.op    = gda_pkg::OP_Q100;
        state_nxt = S_Q400;
      end
      S_Q400: begin
        ctl.op    = gda_pkg::OP_Q400;
        state_nxt = S_Q25;
      end
      S_Q25: begin
        ctl.op    = gda_pkg::OP_Q25;
        state_nxt = S_M365;
      end
      S_M365: begin
        ctl.op    = gda_pkg::OP_M365;
        state_nxt = S_DN;
      end
      S_DN: begin
        ctl.op = gda_pkg::OP_DN;
        priority if (sel_r) begin
          sel_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (sts.cmd == gda_pkg::CMD_DIFF) begin
          sel_nxt   = 1'b1;
          state_nxt = S_Q100;
        end else if (sts.cmd == gda_pkg::CMD_ADD || sts.cmd == gda_pkg::CMD_SUB) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        ctl.op    = gda_pkg::OP_SHIFT;
        state_nxt = sts.neg ? S_DONE : S_CQ;
      end
      S_CQ: begin
        ctl.op = gda_pkg::OP_CQ;
        if (!sts.take) state_nxt = S_CC;
      end
      S_CC: begin
        ctl.op = gda_pkg::OP_CC;
        if (!sts.take) state_nxt = S_CF;
      end
      S_CF: begin
        ctl.op = gda_pkg::OP_CF;
        if (!sts.take) state_nxt = S_CK;
      end
      S_CK: begin
        ctl.op = gda_pkg::OP_CK;
        if (!sts.take) state_nxt = S_CM;
      end
      S_CM: begin
        ctl.op = gda_pkg::OP_CM;
        if (!sts.take) state_nxt = S_FIN;
      end
      S_FIN: begin
        ctl.op    = gda_pkg::OP_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: if (sts.out_free) begin
        ctl.op    = gda_pkg::OP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_Q100))
    else $error("accepted item did not start conversion");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output slot busy");

  a_neg_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && sts.neg) |=> (state_r == S_DONE))
    else $error("negative day number entered carry loop");

  a_out_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == gda_pkg::OP_OUT) |-> sts.out_free)
    else $error("output register overwritten");

endmodule

// File: bench/tb_top.sv
// Testbench for the Gregorian date unit: directed table plus random requests,
// each result checked against its table entry or a calendar predictor. Uses gda_pkg, gda_in_if,
// gda_out_if and gregorian_date_arithmetic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  gda_in_if  in_ch();
  gda_out_if out_ch();

  gregorian_date_arithmetic u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct {
    gda_pkg::in_item_t  req;
    bit                 typed;
    gda_pkg::out_item_t res;
  } row_t;

  gda_pkg::out_item_t expected_dates[$];
  bit                 typed_q[$];
  gda_pkg::out_item_t typed_res_q[$];
  int        fail_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  bit        stim_done = 1'b0;

  function automatic bit is_leap(longint y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    longint n;
    case (m)
      2: n = is_leap(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default: n = 31;
    endcase
    return n;
  endfunction

  function automatic longint ordinal_day(longint y, longint m, longint d);
    longint mm;
    longint s;
    mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
    s = d;
    for (longint i = 1; i < mm; i++) s += days_in_month(y, i);
    return s;
  endfunction

  function automatic longint day_index(longint y, longint m, longint d);
    longint prior;
    prior = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    return prior + ordinal_day(y, m, d) - 1;
  endfunction

  function automatic void date_of_index(longint n, output longint y, output longint m,
                                        output longint d);
    longint r;
    y = 400 * (n / 146097);
    r = n % 146097;
    m = 1;
    while (r >= (is_leap(y) ? 366 : 365)) begin
      r -= is_leap(y) ? 366 : 365;
      y++;
    end
    while (m < 12 && r >= days_in_month(y, m)) begin
      r -= days_in_month(y, m);
      m++;
    end
    d = r + 1;
  endfunction

  function automatic gda_pkg::out_item_t predict_date(gda_pkg::in_item_t q);
    gda_pkg::out_item_t r;
    longint n1, t, iv, ty, tm, td;
    longint y1, m1, d1, y2, m2, d2;
    y1 = q.year; m1 = q.month; d1 = q.day;
    y2 = q.other_year; m2 = q.other_month; d2 = q.other_day;
    r.result_year = q.year;
    r.result_month = q.month;
    r.result_day = q.day;
    r.out_of_range = 1'b0;
    iv = 0;
    n1 = day_index(y1, m1, d1);
    if (q.command == gda_pkg::CMD_ADD || q.command == gda_pkg::CMD_SUB) begin
      t = (q.command == gda_pkg::CMD_ADD) ? n1 + longint'(q.day_count)
                                          : n1 - longint'(q.day_count);
      if (t < 0) begin
        r.out_of_range = 1'b1;
      end else begin
        date_of_index(t, ty, tm, td);
        if (ty < 1 || ty > gda_pkg::MAX_YEAR || ty > 16383) begin
          r.out_of_range = 1'b1;
        end else begin
          r.result_year = ty[13:0];
          r.result_month = tm[3:0];
          r.result_day = td[4:0];
        end
      end
    end else if (q.command == gda_pkg::CMD_DIFF) begin
      iv = n1 - day_index(y2, m2, d2);
      if (iv > 4194303) iv = 4194303;
      if (iv < -4194304) iv = -4194304;
    end
    r.interval = iv[22:0];
    r.is_greater = (y1 > y2) || (y1 == y2 && m1 > m2) || (y1 == y2 && m1 == m2 && d1 > d2);
    r.is_equal = (y1 == y2) && (m1 == m2) && (d1 == d2);
    r.day_of_year = 9'(ordinal_day(y1, m1, d1));
    return r;
  endfunction

  function automatic gda_pkg::in_item_t mk(logic [1:0] c, int y, int m, int d, int n,
                                           int oy, int om, int od);
    gda_pkg::in_item_t q;
    q.command = c; q.year = 14'(y); q.month = 4'(m); q.day = 5'(d);
    q.day_count = 22'(n);
    q.other_year = 14'(oy); q.other_month = 4'(om); q.other_day = 5'(od);
    return q;
  endfunction

  function automatic gda_pkg::out_item_t mk_res(int y, int m, int d, int iv, bit g, bit e,
                                                int doy, bit oor);
    gda_pkg::out_item_t r;
    r.result_year = 14'(y); r.result_month = 4'(m); r.result_day = 5'(d);
    r.interval = 23'(iv);
    r.is_greater = g; r.is_equal = e; r.day_of_year = 9'(doy); r.out_of_range = oor;
    return r;
  endfunction

  function automatic gda_pkg::in_item_t random_request();
    gda_pkg::in_item_t q;
    logic [95:0] raw;
    int sel;
    raw = {$urandom, $urandom, $urandom};
    q = raw[$bits(gda_pkg::in_item_t)-1:0];
    if ($urandom_range(99) < 90) begin
      sel = $urandom_range(99);
      q.command = (sel < 3) ? gda_pkg::CMD_NOP : 2'($urandom_range(2));
      sel = $urandom_range(9);
      q.year = (sel == 0) ? 14'($urandom_range(1, 5)) :
               (sel == 1) ? 14'($urandom_range(9990, 9999)) : 14'($urandom_range(1, 9999));
      q.month = 4'($urandom_range(1, 12));
      q.day = 5'($urandom_range(1, 32'(days_in_month(q.year, q.month))));
      sel = $urandom_range(9);
      q.day_count = (sel < 6) ? 22'($urandom_range(0, 1000)) :
                    (sel < 9) ? 22'($urandom_range(0, 3652058)) : 22'($urandom);
      q.other_year = 14'($urandom_range(1, 9999));
      q.other_month = 4'($urandom_range(1, 12));
      q.other_day = 5'($urandom_range(1, 32'(days_in_month(q.other_year, q.other_month))));
      sel = $urandom_range(9);
      if (sel == 0) begin
        q.other_year = q.year; q.other_month = q.month; q.other_day = q.day;
      end else if (sel == 1) begin
        q.other_year = q.year;
      end
    end
    return q;
  endfunction

  task automatic send_request(gda_pkg::in_item_t q, bit typed, gda_pkg::out_item_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    typed_q.push_back(typed);
    typed_res_q.push_back(res);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = q;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (typed_q.pop_front()) expected_dates.push_back(typed_res_q.pop_front());
      else begin
        void'(typed_res_q.pop_front());
        expected_dates.push_back(predict_date(in_ch.data));
      end
    end
  end

  always @(posedge clk) begin
    gda_pkg::out_item_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_dates.size() == 0) begin
        $error("unexpected result transfer");
        fail_cnt++;
      end else begin
        e = expected_dates.pop_front();
        if (a.result_year !== e.result_year) begin
          $error("result_year exp %0d got %0d", e.result_year, a.result_year); fail_cnt++;
        end
        if (a.result_month !== e.result_month) begin
          $error("result_month exp %0d got %0d", e.result_month, a.result_month); fail_cnt++;
        end
        if (a.result_day !== e.result_day) begin
          $error("result_day exp %0d got %0d", e.result_day, a.result_day); fail_cnt++;
        end
        if (a.interval !== e.interval) begin
          $error("interval exp %0d got %0d", $signed(e.interval), $signed(a.interval));
          fail_cnt++;
        end
        if (a.is_greater !== e.is_greater) begin
          $error("is_greater exp %0d got %0d", e.is_greater, a.is_greater); fail_cnt++;
        end
        if (a.is_equal !== e.is_equal) begin
          $error("is_equal exp %0d got %0d", e.is_equal, a.is_equal); fail_cnt++;
        end
        if (a.day_of_year !== e.day_of_year) begin
          $error("day_of_year exp %0d got %0d", e.day_of_year, a.day_of_year); fail_cnt++;
        end
        if (a.out_of_range !== e.out_of_range) begin
          $error("out_of_range exp %0d got %0d", e.out_of_range, a.out_of_range); fail_cnt++;
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off counted here
  always @(negedge clk) begin
    if (hold_req) begin
      out_ch.ready = 1'b0;
      repeat (400) @(negedge clk);
      hold_req = 1'b0;
    end
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    row_t rows[$];
    gda_pkg::out_item_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rows.push_back('{mk(gda_pkg::CMD_ADD, 2000, 1, 1, 0, 2000, 1, 1), 1'b1,
                     mk_res(2000, 1, 1, 0, 0, 1, 1, 0)});
    rows.push_back('{mk(gda_pkg::CMD_DIFF, 2000, 3, 1, 0, 2000, 2, 28), 1'b1,
                     mk_res(2000, 3, 1, 2, 1, 0, 61, 0)});
    rows.push_back('{mk(gda_pkg::CMD_SUB, 1, 1, 1, 1, 1, 1, 1), 1'b1,
                     mk_res(1, 1, 1, 0, 0, 1, 1, 1)});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 9999, 12, 31, 1, 1, 1, 1), 1'b1,
                     mk_res(9999, 12, 31, 0, 1, 0, 365, 1)});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 1, 1, 1, 3652058, 9999, 12, 31), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_SUB, 9999, 12, 31, 3652058, 1, 1, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 1, 1, 1, 4194303, 1, 1, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_DIFF, 9999, 12, 31, 0, 1, 1, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_DIFF, 1, 1, 1, 0, 9999, 12, 31), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_DIFF, 16383, 15, 31, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_DIFF, 0, 0, 0, 0, 16383, 15, 31), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_NOP, 2024, 2, 29, 100, 2024, 2, 28), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 1900, 2, 28, 1, 1900, 3, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 2000, 2, 28, 1, 2000, 2, 28), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 2023, 12, 31, 1, 2024, 1, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_SUB, 2024, 3, 1, 1, 2024, 2, 29), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_SUB, 2000, 1, 1, 146097, 1, 1, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 2024, 0, 0, 10, 2024, 13, 31), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_SUB, 0, 14, 31, 5, 0, 14, 31), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 9998, 12, 31, 365, 9999, 1, 1), 1'b0, none});
    rows.push_back('{mk(gda_pkg::CMD_ADD, 12000, 6, 15, 20, 12000, 6, 15), 1'b0, none});
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      wait (expected_dates.size() == 0);
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 55 : 25) : 0;
      recv_stall_pct = (ph == 2) ? 55 : ((ph == 3) ? 25 : 0);
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < 270; k++) send_request(random_request(), 1'b0, none);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (expected_dates.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) $display("[gregorian_date_arithmetic] OK");
    else $display("[gregorian_date_arithmetic] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[gregorian_date_arithmetic] ERROR");
    $finish;
  end
endmodule

// File: files.f
hw/rtl/gda_pkg.sv
hw/rtl/gda_in_if.sv
hw/rtl/gda_out_if.sv
hw/rtl/gda_datapath.sv
hw/rtl/gda_ctrl.sv
hw/rtl/gregorian_date_arithmetic.sv
bench/tb_top.sv
